// ----- src/b64e_pkg.sv -----
// Shared types, constants and the symbol lookup for the base64 stream encoder.
// Used by the front end, the group queue, the back end and the top level.
package b64e_pkg;

   localparam int LineBlocksReset = 15;
   localparam int QueueDepthDefault = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // Register indexes of the configuration port.
   localparam logic REG_LINE_BLOCKS = 1'b0;

   // One gathered group: up to three bytes, how many are real, and how it closes.
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] count;
      logic newline;
      logic last;
   } group_type;

   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [5:0] pos;
      pos = 6'd63 - v;
      return ALPHABET[{pos, 3'b000} +: 8];
   endfunction

endpackage

// ----- src/base64_stream_encoder_core.sv -----
// Base64 stream encoder with line wrapping: one raw byte per input item, one
// character per result item. The input side takes up to one byte per cycle
// while the group queue has room; the output register delivers one character
// per cycle while the receiver is ready: four for each group, and a newline
// where one follows. The single character output stage bounds the rate;
// QUEUE_DEPTH groups may wait between the byte gatherer and the character
// stage. The last byte of a stream yields its final group, padded if short,
// and a closing newline that carries tlast.
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_char
   output logic        rsp_tlast,    // last_char
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]          line_blocks_ff, line_blocks_in;
   logic                reg_index;
   logic                push_valid;
   b64e_pkg::group_type push_data;
   logic                queue_full;
   logic                pop;
   logic                pop_valid;
   b64e_pkg::group_type pop_data;

   assign csr_pready = 1'b1;
   assign reg_index = csr_paddr[2];

   always_comb begin
      line_blocks_in = line_blocks_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          reg_index == b64e_pkg::REG_LINE_BLOCKS) begin
         line_blocks_in = csr_pwdata[7:0];
      end
      csr_prdata = (reg_index == b64e_pkg::REG_LINE_BLOCKS) ?
                   {24'd0, line_blocks_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_blocks_ff <= 8'(b64e_pkg::LineBlocksReset);
      end else begin
         line_blocks_ff <= line_blocks_in;
      end
   end

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .line_blocks (line_blocks_ff),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   b64e_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/b64e_front.sv -----
// Front end of the base64 stream encoder: accepts bytes, gathers groups of three
// and tracks line position. Depends on b64e_pkg.
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // end_of_stream
   input  logic [7:0]          line_blocks,
   input  logic                queue_full,
   output logic                push_valid,
   output b64e_pkg::group_type push_data
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] groups_ff, groups_in;
   logic       accept;
   logic       emit;
   logic [7:0] groups_next;
   logic       wrap;

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;
   assign emit = accept && (req_tlast || count_ff == 2'd2);
   assign groups_next = groups_ff + 8'd1;
   assign wrap = groups_next >= line_blocks;

   always_comb begin
      held0_in = held0_ff;
      held1_in = held1_ff;
      count_in = count_ff;
      groups_in = groups_ff;
      push_valid = emit;
      push_data.b0 = (count_ff == 2'd0) ? req_tdata : held0_ff;
      push_data.b1 = (count_ff == 2'd1) ? req_tdata :
                     ((count_ff == 2'd2) ? held1_ff : 8'd0);
      push_data.b2 = (count_ff == 2'd2) ? req_tdata : 8'd0;
      push_data.count = count_ff + 2'd1;
      push_data.newline = req_tlast || wrap;
      push_data.last = req_tlast;
      if (accept) begin
         if (emit) begin
            count_in = 2'd0;
            if (req_tlast || wrap) begin
               groups_in = 8'd0;
            end else begin
               groups_in = groups_next;
            end
         end else begin
            if (count_ff == 2'd0) begin
               held0_in = req_tdata;
            end else begin
               held1_in = req_tdata;
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         count_ff <= 2'd0;
         groups_ff <= 8'd0;
      end else begin
         count_ff <= count_in;
         groups_ff <= groups_in;
      end
   end

endmodule

// ----- src/b64e_queue.sv -----
// Short queue of gathered groups between the front and the back end.
// Depends on b64e_pkg for the group record.
module b64e_queue #(
   parameter int QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  b64e_pkg::group_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output b64e_pkg::group_type pop_data
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QUEUE_DEPTH - 1);

   b64e_pkg::group_type entries_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   fill_ff, fill_in;
   logic                push;

   assign full = fill_ff == (PtrWidth+1)'(QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign push = push_valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

`ifndef SYNTH
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("group queue popped while empty");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (PtrWidth+1)'(QUEUE_DEPTH))
      else $error("group queue fill count beyond depth");
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("group pushed into a full queue");
`endif

endmodule

// ----- src/b64e_back.sv -----
// Back end of the base64 stream encoder: turns each queued group into four
// characters and an optional newline, one per cycle while not stalled. Depends on b64e_pkg.
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  b64e_pkg::group_type pop_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_char
   output logic                rsp_tlast    // last_char
);

   localparam logic [2:0] POS_SYM0 = 3'd0;
   localparam logic [2:0] POS_SYM1 = 3'd1;
   localparam logic [2:0] POS_SYM2 = 3'd2;
   localparam logic [2:0] POS_SYM3 = 3'd3;
   localparam logic [2:0] POS_NEWLINE = 3'd4;

   b64e_pkg::group_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       load;
   logic       final_char;
   logic [7:0] next_char;

   assign load = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign final_char = (pos_ff == POS_NEWLINE) || (pos_ff == POS_SYM3 && !cur_ff.newline);
   assign pop = pop_valid && (!cur_valid_ff || (load && final_char));

   always_comb begin
      case (pos_ff)
         POS_SYM0: next_char = b64e_pkg::sym(cur_ff.b0[7:2]);
         POS_SYM1: next_char = b64e_pkg::sym({cur_ff.b0[1:0], cur_ff.b1[7:4]});
         POS_SYM2: next_char = (cur_ff.count > 2'd1) ?
                               b64e_pkg::sym({cur_ff.b1[3:0], cur_ff.b2[7:6]}) :
                               b64e_pkg::PAD_CHAR;
         POS_SYM3: next_char = (cur_ff.count > 2'd2) ?
                               b64e_pkg::sym(cur_ff.b2[5:0]) : b64e_pkg::PAD_CHAR;
         default:  next_char = b64e_pkg::NEWLINE_CHAR;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = next_char;
         rsp_last_in = (pos_ff == POS_NEWLINE) && cur_ff.last;
         if (final_char) begin
            cur_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         cur_in = pop_data;
         cur_valid_in = 1'b1;
         pos_in = POS_SYM0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff <= POS_SYM0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;

`ifndef SYNTH
   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_char_ff == b64e_pkg::NEWLINE_CHAR)
      else $error("last character is not a newline");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> pos_ff <= POS_NEWLINE)
      else $error("character position out of range");
   a_newline_pos: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && pos_ff == POS_NEWLINE |-> cur_ff.newline)
      else $error("newline position reached for a group without newline");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the base64 stream encoder: a directed table, then random streams.
// Results are checked against a line-wrapping encoder kept in this file.
// Depends on b64e_pkg and base64_stream_encoder_core from the src folder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] LINE_BLOCKS_ADDR = {b64e_pkg::REG_LINE_BLOCKS, 2'b00};
   localparam logic [2:0] UNUSED_ADDR = 3'd4;
   localparam int RANDOM_BYTES = 187;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         eos;
      logic [2:0]   addr;
      logic [2:0]   typed_n;
      logic [39:0]  typed;
   } row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   localparam int DIR_ROWS = 27;
   localparam row_type DIRECTED [DIR_ROWS] = '{
      '{ROW_BYTE,  8'h00, 1'b1, 3'd0, 3'd5, "AA==\n"},
      '{ROW_BYTE,  8'hFF, 1'b1, 3'd0, 3'd5, "/w==\n"},
      '{ROW_BYTE,  8'hFF, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hFF, 1'b1, 3'd0, 3'd5, "//8=\n"},
      '{ROW_BYTE,  8'hFF, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hFF, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hFF, 1'b1, 3'd0, 3'd5, "////\n"},
      '{ROW_WRITE, 8'd1,  1'b0, LINE_BLOCKS_ADDR, 3'd0, 40'd0},
      '{ROW_WRITE, 8'h55, 1'b0, UNUSED_ADDR, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h4D, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h61, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h6E, 1'b0, 3'd0, 3'd5, "TWFu\n"},
      '{ROW_BYTE,  8'hFB, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hEF, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hBE, 1'b1, 3'd0, 3'd0, 40'd0},
      '{ROW_WRITE, 8'd3,  1'b0, LINE_BLOCKS_ADDR, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h14, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hFB, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h9C, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h03, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'hD8, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h7E, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_WRITE, 8'd0,  1'b0, LINE_BLOCKS_ADDR, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h12, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h34, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h56, 1'b0, 3'd0, 3'd0, 40'd0},
      '{ROW_BYTE,  8'h80, 1'b1, 3'd0, 3'd0, 40'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;    // end_of_stream
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] out_char
   logic        rsp_tlast;           // last_char
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Encoder state as seen from outside, plus the line length register.
   logic [7:0] line_len = 8'(b64e_pkg::LineBlocksReset);
   logic [7:0] held [2] = '{8'd0, 8'd0};
   logic [1:0] n_held = 2'd0;
   logic [7:0] line_pos = 8'd0;
   logic [7:0] step_ch [5];
   logic       step_last [5];

   char_item_type pending_chars [$];
   int error_count = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int streams_sent = 0;
   int chars_checked = 0;
   int writes_done = 0;
   int hold_requests = 0;
   int holds_done = 0;
   bit sender_quiet = 1'b0;

   base64_stream_encoder_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (w < 8'd26) return "A" + w;
      if (w < 8'd52) return "a" + w - 8'd26;
      if (w < 8'd62) return "0" + w - 8'd52;
      return (w == 8'd62) ? "+" : "/";
   endfunction

   // Advances the encoder by one byte and leaves its characters in step_ch/step_last.
   function automatic int encode_byte(input logic [7:0] data, input logic eos);
      logic [2:0] cnt;
      logic [7:0] b0, b1, b2;
      int n;
      if (!eos && n_held < 2'd2) begin
         held[n_held[0]] = data;
         n_held = n_held + 2'd1;
         return 0;
      end
      cnt = {1'b0, n_held} + 3'd1;
      b0 = (cnt == 3'd1) ? data : held[0];
      b1 = (cnt == 3'd2) ? data : ((cnt == 3'd3) ? held[1] : 8'd0);
      b2 = (cnt == 3'd3) ? data : 8'd0;
      step_ch[0] = b64_symbol(b0[7:2]);
      step_ch[1] = b64_symbol({b0[1:0], b1[7:4]});
      step_ch[2] = (cnt > 3'd1) ? b64_symbol({b1[3:0], b2[7:6]}) : b64e_pkg::PAD_CHAR;
      step_ch[3] = (cnt > 3'd2) ? b64_symbol(b2[5:0]) : b64e_pkg::PAD_CHAR;
      for (int k = 0; k < 5; k++) step_last[k] = 1'b0;
      n = 4;
      line_pos = line_pos + 8'd1;
      n_held = 2'd0;
      if (eos) begin
         step_ch[4] = b64e_pkg::NEWLINE_CHAR;
         step_last[4] = 1'b1;
         n = 5;
         held[0] = 8'd0;
         held[1] = 8'd0;
         line_pos = 8'd0;
      end else if (line_pos >= line_len) begin
         step_ch[4] = b64e_pkg::NEWLINE_CHAR;
         n = 5;
         line_pos = 8'd0;
      end
      return n;
   endfunction

   task automatic log_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("tb_top mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_char(input logic [7:0] ch, input logic last);
      char_item_type want;
      if (pending_chars.size() == 0) begin
         log_mismatch($sformatf("unexpected char %h last %b", ch, last));
      end else begin
         want = pending_chars.pop_front();
         chars_checked++;
         if (ch !== want.ch || last !== want.last)
            log_mismatch($sformatf("char expected %h last %b, got %h last %b",
                                   want.ch, want.last, ch, last));
      end
   endtask

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_byte(input logic [7:0] data, input logic eos,
                            input logic [2:0] typed_n, input logic [39:0] typed);
      int gap;
      int r;
      int n;
      char_item_type item;
      gap = 0;
      if (!sender_quiet) begin
         r = $urandom_range(0, 9);
         if (r == 9) gap = $urandom_range(8, 40);
         else if (r >= 6) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      n = encode_byte(data, eos);
      if (typed_n == 3'd0) begin
         for (int k = 0; k < n; k++) begin
            item.ch = step_ch[k];
            item.last = step_last[k];
            pending_chars.push_back(item);
         end
      end else begin
         for (int k = 0; k < int'(typed_n); k++) begin
            item.ch = typed[39-8*k -: 8];
            item.last = eos && (k == int'(typed_n) - 1);
            pending_chars.push_back(item);
         end
      end
      bytes_sent++;
      if (eos) streams_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == LINE_BLOCKS_ADDR) line_len = value;
      writes_done++;
      @(posedge clock);
   endtask

   task automatic check_line_blocks();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= LINE_BLOCKS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {24'd0, line_len})
         log_mismatch($sformatf("line_blocks read expected %h, got %h", line_len, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : receiver
      int stall_left;
      int quiet_left;
      int hold_left;
      stall_left = 0;
      quiet_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_char(rsp_tdata, rsp_tlast);
         if (holds_done < hold_requests) begin
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0)
               stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   initial begin : stimulus
      int random_bytes;
      int phase;
      int streams;
      int len;
      logic [7:0] lb;
      logic [7:0] data;
      random_bytes = 0;
      phase = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_line_blocks();

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_WRITE) begin
            settle();
            write_csr(DIRECTED[r].addr, DIRECTED[r].value);
            check_line_blocks();
         end else begin
            send_byte(DIRECTED[r].value, DIRECTED[r].eos, DIRECTED[r].typed_n,
                      DIRECTED[r].typed);
         end
      end

      while (random_bytes < RANDOM_BYTES) begin
         settle();
         if (phase == 0) lb = 8'd255;
         else if (phase == 1) lb = 8'd1;
         else if ($urandom_range(0, 4) == 0) lb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         else lb = 8'($urandom_range(1, 6));
         write_csr(LINE_BLOCKS_ADDR, lb);
         check_line_blocks();
         streams = $urandom_range(1, 4);
         for (int s = 0; s < streams; s++) begin
            if (phase == 0 && s == 0) begin
               // A long back-to-back stream against a stalled receiver fills the queue.
               len = 45;
               sender_quiet = 1'b1;
               hold_requests = 1;
            end else begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                                 : $urandom_range(1, 9);
               sender_quiet = ($urandom_range(0, 3) == 0);
            end
            if (len > RANDOM_BYTES - random_bytes) len = RANDOM_BYTES - random_bytes;
            for (int i = 0; i < len; i++) begin
               // Changing the line length mid-stream must keep the held bytes.
               if (i > 0 && i == len / 2 && $urandom_range(0, 3) == 0) begin
                  settle();
                  write_csr(LINE_BLOCKS_ADDR, 8'($urandom_range(1, 5)));
                  check_line_blocks();
               end
               if ($urandom_range(0, 7) == 0) data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else data = 8'($urandom_range(0, 255));
               send_byte(data, i == len - 1, 3'd0, 40'd0);
               random_bytes++;
            end
         end
         phase++;
      end

      settle();
      $display("tb_top run: %0d bytes in %0d streams, %0d characters checked,",
               bytes_sent, streams_sent, chars_checked);
      $display("tb_top run: %0d register writes, %0d long receiver hold(s)",
               writes_done, holds_done);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
